// ===== hdl/npsp_pkg.sv =====
// Package for the NMEA position sentence parser.
// Types, character codes, register indexes and digit arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package npsp_pkg;

  localparam int unsigned TAG_W       = 40;
  localparam int unsigned FIELD_NUM_W = 5;
  localparam int unsigned VAL_W       = 30;
  localparam int unsigned CFG_DATA_W  = 40;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned ACC_WIDE_W  = 34;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SENTENCE_TAG = 2'd0,
    CFG_LAT_FIELD    = 2'd1,
    CFG_LON_FIELD    = 2'd2
  } cfg_index_t;

  localparam logic [TAG_W-1:0]       TAG_RESET       = 40'h4750474741;
  localparam logic [FIELD_NUM_W-1:0] LAT_FIELD_RESET = 5'd2;
  localparam logic [FIELD_NUM_W-1:0] LON_FIELD_RESET = 5'd4;
  localparam logic [FIELD_NUM_W-1:0] COMMA_MAX       = 5'd31;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [VAL_W-1:0] MAX_VAL     = 30'd999999999;
  localparam logic [2:0]       FRAC_DIGITS = 3'd4;
  localparam logic [2:0]       TAG_LAST    = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TAG  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [TAG_W-1:0]       sentence_tag;
    logic [FIELD_NUM_W-1:0] lat_field_number;
    logic [FIELD_NUM_W-1:0] lon_field_number;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] latitude_scaled;
    logic [VAL_W-1:0] longitude_scaled;
  } result_t;

  // weight of a fraction digit at position pos (1 = tenths) in units of 1e-4
  function automatic logic [9:0] frac_weight(input logic [2:0] pos);
    logic [9:0] w;
    case (pos)
      3'd1:    w = 10'd1000;
      3'd2:    w = 10'd100;
      3'd3:    w = 10'd10;
      3'd4:    w = 10'd1;
      default: w = 10'd0;
    endcase
    return w;
  endfunction

  function automatic logic [VAL_W-1:0] add_int_digit(input logic [VAL_W-1:0] acc,
                                                     input logic [3:0] d);
    logic [ACC_WIDE_W-1:0] v;
    v = ({4'd0, acc} * 34'd10) + ({30'd0, d} * 34'd10000);
    return (v > {4'd0, MAX_VAL}) ? MAX_VAL : v[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] add_frac_digit(input logic [VAL_W-1:0] acc,
                                                      input logic [3:0] d,
                                                      input logic [2:0] pos);
    logic [VAL_W:0] v;
    v = {1'b0, acc} + {17'd0, (14'(d) * 14'(frac_weight(pos)))};
    return (v > {1'b0, MAX_VAL}) ? MAX_VAL : v[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/npsp_byte_if.sv =====
// Byte stream channel: valid/ready handshake carrying one received byte.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface npsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/npsp_pos_if.sv =====
// Position result channel: valid/ready handshake carrying scaled lat/lon.
// Depends on npsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface npsp_pos_if;
  logic                      valid;
  logic                      ready;
  logic [npsp_pkg::VAL_W-1:0] latitude_scaled;
  logic [npsp_pkg::VAL_W-1:0] longitude_scaled;

  modport source (output valid, output latitude_scaled, output longitude_scaled,
                  input ready);
  modport sink   (input valid, input latitude_scaled, input longitude_scaled,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/npsp_cfg_regs.sv =====
// Configuration registers of the sentence parser: tag and field numbers.
// Depends on npsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npsp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [npsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [npsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output npsp_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sentence_tag     <= npsp_pkg::TAG_RESET;
      cfg.lat_field_number <= npsp_pkg::LAT_FIELD_RESET;
      cfg.lon_field_number <= npsp_pkg::LON_FIELD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        npsp_pkg::CFG_SENTENCE_TAG:
          cfg.sentence_tag <= cfg_wdata[npsp_pkg::TAG_W-1:0];
        npsp_pkg::CFG_LAT_FIELD:
          cfg.lat_field_number <= cfg_wdata[npsp_pkg::FIELD_NUM_W-1:0];
        npsp_pkg::CFG_LON_FIELD:
          cfg.lon_field_number <= cfg_wdata[npsp_pkg::FIELD_NUM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/npsp_core.sv =====
// Parser state and per-byte update: tag match, comma count, accumulators.
// Depends on npsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npsp_core (
  input  logic                   clk,
  input  logic                   rst,
  input  npsp_pkg::cfg_t         cfg,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output npsp_pkg::result_t      result
);

  npsp_pkg::phase_t                   phase, phase_next;
  logic [2:0]                         tag_chars_seen, tag_chars_seen_next;
  logic [npsp_pkg::TAG_W-1:0]         tag_shift, tag_shift_next;
  logic [npsp_pkg::FIELD_NUM_W-1:0]   commas_seen, commas_seen_next;
  logic [npsp_pkg::VAL_W-1:0]         lat_accum, lat_accum_next;
  logic [npsp_pkg::VAL_W-1:0]         lon_accum, lon_accum_next;
  logic                               point_seen, point_seen_next;
  logic [2:0]                         frac_digits, frac_digits_next;

  logic       in_lat, in_lon, is_digit;
  logic [3:0] digit;
  logic [2:0] pos;

  assign in_lat   = (commas_seen == cfg.lat_field_number);
  assign in_lon   = (commas_seen == cfg.lon_field_number);
  assign is_digit = (rx_byte >= npsp_pkg::CH_ZERO) && (rx_byte <= npsp_pkg::CH_NINE);
  assign digit    = 4'(rx_byte - npsp_pkg::CH_ZERO);
  assign pos      = frac_digits + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= npsp_pkg::PH_IDLE;
      tag_chars_seen <= '0;
      commas_seen    <= '0;
      point_seen     <= 1'b0;
      frac_digits    <= '0;
    end else begin
      phase          <= phase_next;
      tag_chars_seen <= tag_chars_seen_next;
      commas_seen    <= commas_seen_next;
      point_seen     <= point_seen_next;
      frac_digits    <= frac_digits_next;
    end
  end

  always_ff @(posedge clk) begin
    tag_shift <= tag_shift_next;
    lat_accum <= lat_accum_next;
    lon_accum <= lon_accum_next;
  end

  always_comb begin
    phase_next          = phase;
    tag_chars_seen_next = tag_chars_seen;
    tag_shift_next      = tag_shift;
    commas_seen_next    = commas_seen;
    lat_accum_next      = lat_accum;
    lon_accum_next      = lon_accum;
    point_seen_next     = point_seen;
    frac_digits_next    = frac_digits;
    result.valid            = 1'b0;
    result.latitude_scaled  = lat_accum;
    result.longitude_scaled = lon_accum;

    if (step) begin
      if (rx_byte == npsp_pkg::CH_DOLLAR) begin
        phase_next          = npsp_pkg::PH_TAG;
        tag_chars_seen_next = '0;
        tag_shift_next      = '0;
      end else begin
        unique case (phase)
          npsp_pkg::PH_TAG: begin
            tag_shift_next = {tag_shift[npsp_pkg::TAG_W-9:0], rx_byte};
            if (tag_chars_seen == npsp_pkg::TAG_LAST) begin
              tag_chars_seen_next = '0;
              if (tag_shift_next == cfg.sentence_tag) begin
                phase_next       = npsp_pkg::PH_BODY;
                commas_seen_next = '0;
                lat_accum_next   = '0;
                lon_accum_next   = '0;
                point_seen_next  = 1'b0;
                frac_digits_next = '0;
              end else begin
                phase_next = npsp_pkg::PH_IDLE;
              end
            end else begin
              tag_chars_seen_next = tag_chars_seen + 3'd1;
            end
          end
          npsp_pkg::PH_BODY: begin
            if (rx_byte == npsp_pkg::CH_COMMA) begin
              if (in_lon) begin
                result.valid = 1'b1;
                phase_next   = npsp_pkg::PH_IDLE;
              end else begin
                if (commas_seen != npsp_pkg::COMMA_MAX) begin
                  commas_seen_next = commas_seen + 5'd1;
                end
                point_seen_next  = 1'b0;
                frac_digits_next = '0;
              end
            end else if (in_lat || in_lon) begin
              if (rx_byte == npsp_pkg::CH_POINT) begin
                point_seen_next = 1'b1;
              end else if (is_digit) begin
                if (!point_seen) begin
                  if (in_lat) lat_accum_next = npsp_pkg::add_int_digit(lat_accum, digit);
                  if (in_lon) lon_accum_next = npsp_pkg::add_int_digit(lon_accum, digit);
                end else if (frac_digits < npsp_pkg::FRAC_DIGITS) begin
                  if (in_lat) begin
                    lat_accum_next = npsp_pkg::add_frac_digit(lat_accum, digit, pos);
                  end
                  if (in_lon) begin
                    lon_accum_next = npsp_pkg::add_frac_digit(lon_accum, digit, pos);
                  end
                  frac_digits_next = pos;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nmea_position_sentence_parser.sv =====
// Top level of the NMEA position sentence parser: input and result registers
// around the per-byte core. Depends on npsp_pkg, npsp_byte_if, npsp_pos_if,
// npsp_cfg_regs and npsp_core.
//
//   channel  dir  beat contents
//   rx       in   rx_byte[7:0]
//   pos      out  latitude_scaled[29:0], longitude_scaled[29:0]
//   cfg_*    in   cfg_we, cfg_index[1:0], cfg_wdata[39:0]
//
// One byte per cycle sustained while pos is not stalled. A byte is held in the input
// register and its result, if any, is loaded into the result register as the core steps.
// A stalled result holds the core; one further byte waits in the input register.
// Synchronous reset restores the configuration defaults and idles the parser.
`timescale 1ns / 1ps
`default_nettype none

module nmea_position_sentence_parser (
  input  logic                             clk,
  input  logic                             rst,
  npsp_byte_if.sink                        rx,
  npsp_pos_if.source                       pos,
  input  logic                             cfg_we,
  input  logic [npsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [npsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  npsp_pkg::cfg_t    cfg;
  npsp_pkg::result_t result;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       step;
  logic       out_valid;
  logic [npsp_pkg::VAL_W-1:0] out_lat, out_lon;

  assign step     = byte_valid && (!out_valid || pos.ready);
  assign rx.ready = !byte_valid || step;

  npsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  npsp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .rx_byte (byte_data),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      byte_data <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.valid;
    end else if (pos.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      out_lat <= result.latitude_scaled;
      out_lon <= result.longitude_scaled;
    end
  end

  assign pos.valid            = out_valid;
  assign pos.latitude_scaled  = out_lat;
  assign pos.longitude_scaled = out_lon;

endmodule

`default_nettype wire
